// ===== rtl/core/cps_pkg.sv =====
// cps_pkg: shared constants, types and ordering functions of the cluster priority sorter
// no dependencies; used by every module of the block

package cps_pkg;

  localparam int SLOTS       = 16;
  localparam int WEIGHT_BITS = 16;
  localparam int BIRTH_BITS  = 32;

  localparam int IDX_W    = $clog2(SLOTS);
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int OPCODE_W = 2;
  localparam int ID_W     = 4;
  localparam int RANK_W   = 4;

  localparam logic [CNT_W-1:0] CNT_SLOTS = CNT_W'(SLOTS);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SLOTS - 1);

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_RECALC = 2'd1,
    OP_TRACK  = 2'd2
  } opcode_e;

  localparam logic KIND_ORDER  = 1'b0;
  localparam logic KIND_TARGET = 1'b1;

  // birth order classes, lower class sorts first
  localparam logic [1:0] CLS_LIVE  = 2'd0;
  localparam logic [1:0] CLS_UNSET = 2'd1;
  localparam logic [1:0] CLS_EMPTY = 2'd2;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [BIRTH_BITS-1:0]  birth;
    logic                   empty;
  } rec_t;

  localparam rec_t REC_RESET = '{weight: '0, birth: '0, empty: 1'b1};

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    rec_t             data;
  } rec_wr_t;

  typedef struct packed {
    logic             wen_w;
    logic             wen_b;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] id;
  } ord_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] w_id;
    logic [IDX_W-1:0] b_id;
  } ord_rd_t;

  // slot a ahead of slot b in weight order
  function automatic logic weight_before(rec_t ra, logic [IDX_W-1:0] ia,
                                         rec_t rb, logic [IDX_W-1:0] ib);
    if (ra.weight != rb.weight) return ra.weight > rb.weight;
    return ia < ib;
  endfunction

  function automatic logic [1:0] birth_class(rec_t r);
    if (r.empty) return CLS_EMPTY;
    if (r.birth == '0) return CLS_UNSET;
    return CLS_LIVE;
  endfunction

  // slot a ahead of slot b in birth order
  function automatic logic birth_before(rec_t ra, logic [IDX_W-1:0] ia,
                                        rec_t rb, logic [IDX_W-1:0] ib);
    logic [1:0] ca;
    logic [1:0] cb;
    ca = birth_class(ra);
    cb = birth_class(rb);
    if (ca != cb) return ca < cb;
    if (ca == CLS_LIVE && ra.birth != rb.birth) return ra.birth < rb.birth;
    return ia < ib;
  endfunction

endpackage

// ===== rtl/core/cluster_priority_sorter_core.sv =====
// cluster_priority_sorter_core: top level, command sequencer around the record and order memories
// depends on cps_pkg, cps_rec_ram, cps_ord_ram

// A transaction is taken when start_i is high and busy_o is low. A write
// transaction (opcode write) loads one slot record in the same cycle and
// keeps busy_o low, so writes can follow back to back. A recalc transaction
// ranks every slot against every other one, reading the record memory one
// slot per cycle through its single read port: for each slot it reads the
// record, latches it, scans every record and stores one weight order and one
// birth order entry; then it streams the stored orders out of the order
// memory, one result per cycle with rank 0 first and last_o on the final one.
// A track transaction walks the stored weight order one rank per cycle. Each
// result is shown for a single cycle with result_valid_o; the receiver has no
// way to stall, so it must take every strobed cycle. The weight order used by
// track is that of the latest recalc (identity order after reset).

module cluster_priority_sorter_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [cps_pkg::OPCODE_W-1:0]   opcode_i,
  input  logic [3:0]                     slot_id_i,
  input  logic [15:0]                    slot_weight_i,
  input  logic [31:0]                    slot_birth_i,
  input  logic                           slot_empty_i,
  input  logic                           slot_tracking_i,
  output logic                           result_valid_o,
  output logic                           kind_o,
  output logic [cps_pkg::RANK_W-1:0]     rank_o,
  output logic [cps_pkg::ID_W-1:0]       weight_rank_id_o,
  output logic [cps_pkg::ID_W-1:0]       birth_rank_id_o,
  output logic [cps_pkg::ID_W-1:0]       target_id_o,
  output logic                           all_busy_o,
  output logic                           last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUTER,   // read the record being ranked
    S_REF,     // latch it, start the scan
    S_SCAN,    // compare against every other record, one per cycle
    S_WR_W,    // store weight order entry
    S_WR_B,    // store birth order entry
    S_EMIT,    // stream orders out
    S_TRACK    // walk weight order for the first untracked slot
  } state_e;

  state_e                       state_q;
  cps_pkg::opcode_e             op;

  logic [cps_pkg::IDX_W-1:0]    i_q;
  logic [cps_pkg::CNT_W-1:0]    j_q;
  logic [cps_pkg::CNT_W-1:0]    k_q;
  logic                         pend_q;
  logic [cps_pkg::IDX_W-1:0]    rd_id_q;
  cps_pkg::rec_t                ref_q;
  logic [cps_pkg::IDX_W-1:0]    wpos_q;
  logic [cps_pkg::IDX_W-1:0]    bpos_q;
  logic [cps_pkg::SLOTS-1:0]    tracking_q;

  logic                         res_valid_q;
  logic                         kind_q;
  logic [cps_pkg::RANK_W-1:0]   rank_q;
  logic [cps_pkg::ID_W-1:0]     wid_q;
  logic [cps_pkg::ID_W-1:0]     bid_q;
  logic [cps_pkg::ID_W-1:0]     tid_q;
  logic                         all_busy_q;
  logic                         last_q;

  cps_pkg::rec_wr_t             rec_wr;
  logic [cps_pkg::IDX_W-1:0]    rec_rd_addr;
  cps_pkg::rec_t                rec_rd;
  cps_pkg::ord_wr_t             ord_wr;
  cps_pkg::ord_rd_t             ord_rd;

  logic                         idle_start;
  logic                         wr_in_range;
  logic [cps_pkg::IDX_W-1:0]    wr_idx;
  logic                         cmp_live;
  logic [cps_pkg::IDX_W-1:0]    tgt;
  logic                         tgt_hit;

  assign op          = cps_pkg::opcode_e'(opcode_i);
  assign idle_start  = start_i && (state_q == S_IDLE);
  assign wr_in_range = int'(slot_id_i) < cps_pkg::SLOTS;
  assign wr_idx      = cps_pkg::IDX_W'(slot_id_i);

  // a scanned record counts unless it is the record being ranked
  assign cmp_live = pend_q && (rd_id_q != i_q);

  // track: stop at the first untracked slot, or at the last rank
  assign tgt     = ord_rd.w_id;
  assign tgt_hit = !tracking_q[tgt] || (rd_id_q == cps_pkg::IDX_LAST);

  always_comb begin
    rec_wr.en          = idle_start && (op == cps_pkg::OP_WRITE) && wr_in_range;
    rec_wr.addr        = wr_idx;
    rec_wr.data.weight = cps_pkg::WEIGHT_BITS'(slot_weight_i);
    rec_wr.data.birth  = cps_pkg::BIRTH_BITS'(slot_birth_i);
    rec_wr.data.empty  = slot_empty_i;

    if (state_q == S_REF || state_q == S_SCAN) begin
      rec_rd_addr = j_q[cps_pkg::IDX_W-1:0];
    end else begin
      rec_rd_addr = i_q;
    end

    ord_wr.wen_w = (state_q == S_WR_W);
    ord_wr.wen_b = (state_q == S_WR_B);
    ord_wr.addr  = (state_q == S_WR_B) ? bpos_q : wpos_q;
    ord_wr.id    = i_q;
  end

  cps_rec_ram u_rec_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (rec_wr),
    .rd_addr_i (rec_rd_addr),
    .rd_data_o (rec_rd)
  );

  cps_ord_ram u_ord_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ord_wr),
    .rd_addr_i (k_q[cps_pkg::IDX_W-1:0]),
    .rd_data_o (ord_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pend_q      <= 1'b0;
      rd_id_q     <= '0;
      ref_q       <= cps_pkg::REC_RESET;
      wpos_q      <= '0;
      bpos_q      <= '0;
      tracking_q  <= '0;
      res_valid_q <= 1'b0;
      kind_q      <= cps_pkg::KIND_ORDER;
      rank_q      <= '0;
      wid_q       <= '0;
      bid_q       <= '0;
      tid_q       <= '0;
      all_busy_q  <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          pend_q <= 1'b0;
          if (start_i) begin
            unique case (op)
              cps_pkg::OP_WRITE: begin
                if (wr_in_range) begin
                  tracking_q[wr_idx] <= slot_tracking_i;
                end
              end
              cps_pkg::OP_RECALC: begin
                i_q     <= '0;
                state_q <= S_OUTER;
              end
              cps_pkg::OP_TRACK: begin
                k_q     <= '0;
                state_q <= S_TRACK;
              end
              default: ;
            endcase
          end
        end
        S_OUTER: begin
          j_q     <= '0;
          state_q <= S_REF;
        end
        S_REF: begin
          ref_q   <= rec_rd;
          wpos_q  <= '0;
          bpos_q  <= '0;
          pend_q  <= 1'b1;
          rd_id_q <= j_q[cps_pkg::IDX_W-1:0];
          j_q     <= j_q + 1'b1;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (cmp_live && cps_pkg::weight_before(rec_rd, rd_id_q, ref_q, i_q)) begin
            wpos_q <= wpos_q + 1'b1;
          end
          if (cmp_live && cps_pkg::birth_before(rec_rd, rd_id_q, ref_q, i_q)) begin
            bpos_q <= bpos_q + 1'b1;
          end
          if (pend_q && rd_id_q == cps_pkg::IDX_LAST) begin
            pend_q  <= 1'b0;
            state_q <= S_WR_W;
          end else begin
            pend_q  <= j_q < cps_pkg::CNT_SLOTS;
            rd_id_q <= j_q[cps_pkg::IDX_W-1:0];
            if (j_q < cps_pkg::CNT_SLOTS) begin
              j_q <= j_q + 1'b1;
            end
          end
        end
        S_WR_W: begin
          state_q <= S_WR_B;
        end
        S_WR_B: begin
          if (i_q == cps_pkg::IDX_LAST) begin
            k_q     <= '0;
            state_q <= S_EMIT;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= S_OUTER;
          end
        end
        S_EMIT: begin
          if (pend_q) begin
            res_valid_q <= 1'b1;
            kind_q      <= cps_pkg::KIND_ORDER;
            rank_q      <= cps_pkg::RANK_W'(rd_id_q);
            wid_q       <= cps_pkg::ID_W'(ord_rd.w_id);
            bid_q       <= cps_pkg::ID_W'(ord_rd.b_id);
            tid_q       <= '0;
            all_busy_q  <= 1'b0;
            last_q      <= (rd_id_q == cps_pkg::IDX_LAST);
          end
          if (pend_q && rd_id_q == cps_pkg::IDX_LAST) begin
            pend_q  <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            pend_q  <= k_q < cps_pkg::CNT_SLOTS;
            rd_id_q <= k_q[cps_pkg::IDX_W-1:0];
            if (k_q < cps_pkg::CNT_SLOTS) begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        S_TRACK: begin
          if (pend_q && tgt_hit) begin
            tracking_q[tgt] <= 1'b1;
            res_valid_q     <= 1'b1;
            kind_q          <= cps_pkg::KIND_TARGET;
            rank_q          <= '0;
            wid_q           <= '0;
            bid_q           <= '0;
            tid_q           <= cps_pkg::ID_W'(tgt);
            all_busy_q      <= tracking_q[tgt];
            last_q          <= 1'b1;
            pend_q          <= 1'b0;
            state_q         <= S_IDLE;
          end else begin
            pend_q  <= k_q < cps_pkg::CNT_SLOTS;
            rd_id_q <= k_q[cps_pkg::IDX_W-1:0];
            if (k_q < cps_pkg::CNT_SLOTS) begin
              k_q <= k_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign result_valid_o   = res_valid_q;
  assign kind_o           = kind_q;
  assign rank_o           = rank_q;
  assign weight_rank_id_o = wid_q;
  assign birth_rank_id_o  = bid_q;
  assign target_id_o      = tid_q;
  assign all_busy_o       = all_busy_q;
  assign last_o           = last_q;

endmodule

// ===== rtl/core/cps_rec_ram.sv =====
// cps_rec_ram: slot record memory (weight, birth, empty) with a registered read
// depends on cps_pkg; never-written entries read as the reset record

module cps_rec_ram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cps_pkg::rec_wr_t            wr_i,
  input  logic [cps_pkg::IDX_W-1:0]   rd_addr_i,
  output cps_pkg::rec_t               rd_data_o
);

  cps_pkg::rec_t             mem [cps_pkg::SLOTS];
  logic [cps_pkg::SLOTS-1:0] valid_q;
  cps_pkg::rec_t             rd_data_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : cps_pkg::REC_RESET;

endmodule

// ===== rtl/core/cps_ord_ram.sv =====
// cps_ord_ram: weight order and birth order memory, one entry per rank
// depends on cps_pkg; each field reads as the identity order until written

module cps_ord_ram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cps_pkg::ord_wr_t            wr_i,
  input  logic [cps_pkg::IDX_W-1:0]   rd_addr_i,
  output cps_pkg::ord_rd_t            rd_data_o
);

  cps_pkg::ord_rd_t             mem [cps_pkg::SLOTS];
  logic [cps_pkg::SLOTS-1:0]    wval_q;
  logic [cps_pkg::SLOTS-1:0]    bval_q;
  cps_pkg::ord_rd_t             rd_data_q;
  logic                         rd_wval_q;
  logic                         rd_bval_q;
  logic [cps_pkg::IDX_W-1:0]    rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.wen_w) begin
      mem[wr_i.addr].w_id <= wr_i.id;
    end
    if (wr_i.wen_b) begin
      mem[wr_i.addr].b_id <= wr_i.id;
    end
    rd_data_q <= mem[rd_addr_i];
    rd_addr_q <= rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wval_q    <= '0;
      bval_q    <= '0;
      rd_wval_q <= 1'b0;
      rd_bval_q <= 1'b0;
    end else begin
      if (wr_i.wen_w) begin
        wval_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.wen_b) begin
        bval_q[wr_i.addr] <= 1'b1;
      end
      rd_wval_q <= wval_q[rd_addr_i];
      rd_bval_q <= bval_q[rd_addr_i];
    end
  end

  assign rd_data_o.w_id = rd_wval_q ? rd_data_q.w_id : rd_addr_q;
  assign rd_data_o.b_id = rd_bval_q ? rd_data_q.b_id : rd_addr_q;

endmodule

// ===== rtl/core/cps_checker.sv =====
// cps_checker: port-level assertions for the cluster priority sorter
// depends on cps_pkg; bound to cluster_priority_sorter_core below

module cps_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input logic [cps_pkg::OPCODE_W-1:0]   opcode_i,
  input logic                           result_valid_o,
  input logic                           kind_o,
  input logic [cps_pkg::RANK_W-1:0]     rank_o,
  input logic                           last_o
);

  // order entries of one recalc come on consecutive cycles
  a_burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("recalc burst broken");

  // ranks climb by one within a burst
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> rank_o == $past(rank_o) + 4'd1)
    else $error("rank sequence skipped");

  // a track result carries last_o, as a track transaction gives exactly one result
  a_target_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == cps_pkg::KIND_TARGET |-> last_o)
    else $error("track result without last");

  // recalc and track occupy the block
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o &&
    (opcode_i == cps_pkg::OP_RECALC || opcode_i == cps_pkg::OP_TRACK) |=> busy_o)
    else $error("command not taken");

endmodule

bind cluster_priority_sorter_core cps_checker u_cps_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .opcode_i       (opcode_i),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .rank_o         (rank_o),
  .last_o         (last_o)
);

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for cluster_priority_sorter_core, directed and random traffic
// depends on cps_pkg and the rtl of the block; predicts sort and track results on its own

module testbench;

  // opcode value outside the operation set, the block must ignore it
  localparam logic [cps_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;

  // one recalc ranks every slot and then streams the orders out
  localparam int RECALC_CYCLES = cps_pkg::SLOTS * (cps_pkg::SLOTS + 4) + cps_pkg::SLOTS + 1;
  localparam int SETTLE_CYCLES = RECALC_CYCLES + 20;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_ITEMS  = 445;

  typedef struct packed {
    logic                       kind;
    logic [cps_pkg::RANK_W-1:0] rank;
    logic [cps_pkg::ID_W-1:0]   weight_id;
    logic [cps_pkg::ID_W-1:0]   birth_id;
    logic [cps_pkg::ID_W-1:0]   target;
    logic                       all_busy;
    logic                       last;
  } sorter_result_t;

  logic                         clk_i           = 1'b0;
  logic                         rst_ni          = 1'b0;
  logic                         start_i         = 1'b0;
  logic [cps_pkg::OPCODE_W-1:0] opcode_i        = cps_pkg::OP_WRITE;
  logic [3:0]                   slot_id_i       = '0;
  logic [15:0]                  slot_weight_i   = '0;
  logic [31:0]                  slot_birth_i    = '0;
  logic                         slot_empty_i    = 1'b0;
  logic                         slot_tracking_i = 1'b0;
  logic                         busy_o;
  logic                         result_valid_o;
  logic                         kind_o;
  logic [cps_pkg::RANK_W-1:0]   rank_o;
  logic [cps_pkg::ID_W-1:0]     weight_rank_id_o;
  logic [cps_pkg::ID_W-1:0]     birth_rank_id_o;
  logic [cps_pkg::ID_W-1:0]     target_id_o;
  logic                         all_busy_o;
  logic                         last_o;

  cluster_priority_sorter_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .opcode_i         (opcode_i),
    .slot_id_i        (slot_id_i),
    .slot_weight_i    (slot_weight_i),
    .slot_birth_i     (slot_birth_i),
    .slot_empty_i     (slot_empty_i),
    .slot_tracking_i  (slot_tracking_i),
    .result_valid_o   (result_valid_o),
    .kind_o           (kind_o),
    .rank_o           (rank_o),
    .weight_rank_id_o (weight_rank_id_o),
    .birth_rank_id_o  (birth_rank_id_o),
    .target_id_o      (target_id_o),
    .all_busy_o       (all_busy_o),
    .last_o           (last_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow copy of the slot records and of the stored orders
  logic [cps_pkg::WEIGHT_BITS-1:0] slot_weight_mem [cps_pkg::SLOTS];
  logic [cps_pkg::BIRTH_BITS-1:0]  slot_birth_mem  [cps_pkg::SLOTS];
  logic                            slot_empty_mem  [cps_pkg::SLOTS];
  logic                            slot_track_mem  [cps_pkg::SLOTS];
  logic [cps_pkg::IDX_W-1:0]       by_weight_mem   [cps_pkg::SLOTS];
  logic [cps_pkg::IDX_W-1:0]       by_birth_mem    [cps_pkg::SLOTS];

  // results still owed by the block, oldest first
  sorter_result_t rank_and_target_q [$];

  int unsigned error_count     = 0;
  int unsigned sent_count      = 0;
  int unsigned checked_count   = 0;
  int unsigned saturated_count = 0;
  int unsigned cycle_count     = 0;

  sorter_result_t seen_result;
  sorter_result_t owed_result;

  // ---------------------------------------------------------------------------
  // shadow model of the slot table
  // ---------------------------------------------------------------------------

  task automatic clear_slot_table();
    for (int s = 0; s < cps_pkg::SLOTS; s++) begin
      slot_weight_mem[s] = '0;
      slot_birth_mem[s]  = '0;
      slot_empty_mem[s]  = 1'b1;
      slot_track_mem[s]  = 1'b0;
      by_weight_mem[s]   = cps_pkg::IDX_W'(s);
      by_birth_mem[s]    = cps_pkg::IDX_W'(s);
    end
  endtask

  // heavier slot first, lower id wins a tie
  function automatic bit heavier(int a, int b);
    if (slot_weight_mem[a] != slot_weight_mem[b]) return slot_weight_mem[a] > slot_weight_mem[b];
    return a < b;
  endfunction

  // live slots, then slots with unset birth, then empty slots
  function automatic logic [1:0] age_group(int s);
    if (slot_empty_mem[s]) return cps_pkg::CLS_EMPTY;
    if (slot_birth_mem[s] == '0) return cps_pkg::CLS_UNSET;
    return cps_pkg::CLS_LIVE;
  endfunction

  // older live slot first, lower id wins a tie
  function automatic bit older(int a, int b);
    logic [1:0] ga;
    logic [1:0] gb;
    ga = age_group(a);
    gb = age_group(b);
    if (ga != gb) return ga < gb;
    if (ga == cps_pkg::CLS_LIVE && slot_birth_mem[a] != slot_birth_mem[b])
      return slot_birth_mem[a] < slot_birth_mem[b];
    return a < b;
  endfunction

  // apply one accepted transaction to the shadow table and queue what it owes
  task automatic sort_and_track(logic [cps_pkg::OPCODE_W-1:0] op, logic [3:0] id,
                                logic [15:0] weight, logic [31:0] birth,
                                logic empty, logic tracking);
    sorter_result_t            entry;
    int                        wpos;
    int                        bpos;
    logic [cps_pkg::IDX_W-1:0] chosen;
    bit                        none_free;
    case (op)
      cps_pkg::OP_WRITE: begin
        slot_weight_mem[id] = weight;
        slot_birth_mem[id]  = birth;
        slot_empty_mem[id]  = empty;
        slot_track_mem[id]  = tracking;
      end
      cps_pkg::OP_RECALC: begin
        // position of each slot = number of slots ahead of it
        for (int i = 0; i < cps_pkg::SLOTS; i++) begin
          wpos = 0;
          bpos = 0;
          for (int j = 0; j < cps_pkg::SLOTS; j++) begin
            if (j != i && heavier(j, i)) wpos++;
            if (j != i && older(j, i)) bpos++;
          end
          by_weight_mem[wpos] = cps_pkg::IDX_W'(i);
          by_birth_mem[bpos]  = cps_pkg::IDX_W'(i);
        end
        for (int k = 0; k < cps_pkg::SLOTS; k++) begin
          entry           = '0;
          entry.kind      = cps_pkg::KIND_ORDER;
          entry.rank      = cps_pkg::RANK_W'(k);
          entry.weight_id = by_weight_mem[k];
          entry.birth_id  = by_birth_mem[k];
          entry.last      = (k == cps_pkg::SLOTS - 1);
          rank_and_target_q.push_back(entry);
        end
      end
      cps_pkg::OP_TRACK: begin
        // first untracked slot in the stored weight order, else the slot at its last rank
        chosen    = by_weight_mem[cps_pkg::SLOTS-1];
        none_free = 1'b1;
        for (int k = 0; k < cps_pkg::SLOTS; k++) begin
          if (none_free && !slot_track_mem[by_weight_mem[k]]) begin
            chosen    = by_weight_mem[k];
            none_free = 1'b0;
          end
        end
        slot_track_mem[chosen] = 1'b1;
        if (none_free) saturated_count++;
        entry          = '0;
        entry.kind     = cps_pkg::KIND_TARGET;
        entry.target   = chosen;
        entry.all_busy = none_free;
        entry.last     = 1'b1;
        rank_and_target_q.push_back(entry);
      end
      default: begin
        // unused opcode leaves everything as it was
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // driver: one command transaction, called at a rising edge
  // ---------------------------------------------------------------------------

  // start stays high across back to back transactions so it is never
  // lowered and raised within the same time step
  task automatic send_command(logic [cps_pkg::OPCODE_W-1:0] op, logic [3:0] id,
                              logic [15:0] weight, logic [31:0] birth,
                              logic empty, logic tracking);
    int gap;
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i         <= 1'b1;
    opcode_i        <= op;
    slot_id_i       <= id;
    slot_weight_i   <= weight;
    slot_birth_i    <= birth;
    slot_empty_i    <= empty;
    slot_tracking_i <= tracking;
    // taken at the first edge that sees busy low
    do @(posedge clk_i); while (busy_o);
    sort_and_track(op, id, weight, birth, empty, tracking);
    sent_count++;
  endtask

  task automatic send_write(int id, logic [15:0] weight, logic [31:0] birth,
                            logic empty, logic tracking);
    send_command(cps_pkg::OP_WRITE, 4'(id), weight, birth, empty, tracking);
  endtask

  task automatic send_bare(logic [cps_pkg::OPCODE_W-1:0] op);
    send_command(op, 4'($urandom), 16'($urandom), $urandom, 1'($urandom), 1'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // checker: the receiver cannot stall, every strobed cycle is a result
  // ---------------------------------------------------------------------------

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      seen_result = '{kind: kind_o, rank: rank_o, weight_id: weight_rank_id_o,
                      birth_id: birth_rank_id_o, target: target_id_o,
                      all_busy: all_busy_o, last: last_o};
      if (rank_and_target_q.size() == 0) begin
        $display("%0t: result with nothing outstanding, expected none, actual %0h",
                 $time, seen_result);
        error_count++;
      end else begin
        owed_result = rank_and_target_q.pop_front();
        check_field("kind", owed_result.kind, seen_result.kind);
        check_field("rank", owed_result.rank, seen_result.rank);
        check_field("weight_rank_id", owed_result.weight_id, seen_result.weight_id);
        check_field("birth_rank_id", owed_result.birth_id, seen_result.birth_id);
        check_field("target_id", owed_result.target, seen_result.target);
        check_field("all_busy", owed_result.all_busy, seen_result.all_busy);
        check_field("last", owed_result.last, seen_result.last);
        checked_count++;
      end
    end
  end

  // watchdog on the whole run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // track before any recalc uses the identity order; recalc of an all-empty table
  task automatic test_reset_state();
    send_bare(cps_pkg::OP_TRACK);
    send_bare(cps_pkg::OP_RECALC);
  endtask

  // opcode outside the set is taken but changes nothing
  task automatic test_unused_opcode();
    send_bare(OP_UNUSED);
    send_bare(cps_pkg::OP_TRACK);
  endtask

  // field extremes on both ends of each order
  task automatic test_extreme_records();
    send_write(15, 16'hffff, 32'hffff_ffff, 1'b0, 1'b0);
    send_write(0, 16'h0000, 32'h0000_0000, 1'b0, 1'b1);
    send_write(7, 16'hffff, 32'h0000_0001, 1'b0, 1'b0);
    send_write(3, 16'h1234, 32'hffff_ffff, 1'b1, 1'b1);
    send_bare(cps_pkg::OP_RECALC);
  endtask

  // equal weights and equal births fall back to slot id
  task automatic test_tie_breaks();
    send_write(9, 16'hffff, 32'h0000_0001, 1'b0, 1'b0);
    send_write(2, 16'h0000, 32'h0000_0000, 1'b0, 1'b0);
    send_write(12, 16'h1234, 32'h0000_0000, 1'b1, 1'b0);
    send_bare(cps_pkg::OP_RECALC);
  endtask

  // track keeps using the order of the previous recalc after a write
  task automatic test_stale_order();
    send_write(5, 16'hffff, 32'h0000_0005, 1'b0, 1'b0);
    send_bare(cps_pkg::OP_TRACK);
    send_bare(cps_pkg::OP_TRACK);
    send_bare(cps_pkg::OP_RECALC);
    send_bare(cps_pkg::OP_TRACK);
  endtask

  // small pools make ties common, the rest covers every bit
  function automatic logic [15:0] draw_weight();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2, 3:    return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] draw_birth();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      2, 3:    return 32'($urandom_range(1, 4));
      default: return $urandom;
    endcase
  endfunction

  // writes mostly set the tracking flag so tracks run out of free slots
  task automatic test_random_traffic();
    int pick;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 52)
        send_write($urandom_range(0, cps_pkg::SLOTS - 1), draw_weight(), draw_birth(),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 3) != 0);
      else if (pick < 64)
        send_bare(cps_pkg::OP_RECALC);
      else if (pick < 95)
        send_bare(cps_pkg::OP_TRACK);
      else
        send_bare(OP_UNUSED);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_slot_table();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_unused_opcode();
    test_extreme_records();
    test_tie_breaks();
    test_stale_order();
    test_random_traffic();
    start_i <= 1'b0;

    // drain, then watch a while for stray results
    while (rank_and_target_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (rank_and_target_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, rank_and_target_q.size());
      error_count++;
    end

    $display("sent %0d command transactions, compared %0d results", sent_count, checked_count);
    $display("%0d tracks found every slot already tracked", saturated_count);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cps_pkg.sv
rtl/core/cps_rec_ram.sv
rtl/core/cps_ord_ram.sv
rtl/core/cluster_priority_sorter_core.sv
rtl/core/cps_checker.sv
tb/sv/testbench.sv
